@@ rtl/isl_pkg.sv @@
package isl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 4;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PREPEND   = 4'd0,
    CMD_APPEND    = 4'd1,
    CMD_POP_LAST  = 4'd2,
    CMD_POP_FIRST = 4'd3,
    CMD_FIRST     = 4'd4,
    CMD_LAST      = 4'd5,
    CMD_GET       = 4'd6,
    CMD_REMOVE    = 4'd7,
    CMD_INSERT    = 4'd8,
    CMD_CLEAR     = 4'd9
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [ST_W-1:0]         status;
    logic [LEN_W-1:0]        length;
  } out_item_t;

  // Broadcast to every cell: open a gap at pos, or close the slot at pos.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] pos;
  } cell_ctl_t;

endpackage

@@ rtl/isl_cell.sv @@
module isl_cell (
  input  logic                           clk,
  input  isl_pkg::cell_ctl_t             ctl,
  input  logic [isl_pkg::IDX_W-1:0]      cell_idx,
  input  logic signed [isl_pkg::VAL_W-1:0] din,
  input  logic signed [isl_pkg::VAL_W-1:0] left_val,
  input  logic signed [isl_pkg::VAL_W-1:0] right_val,
  output logic signed [isl_pkg::VAL_W-1:0] cell_val
);

  logic signed [isl_pkg::VAL_W-1:0] val_r;
  logic signed [isl_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (cell_idx == ctl.pos) begin
        val_nxt = din;
      end else if (cell_idx > ctl.pos) begin
        val_nxt = left_val;
      end
    end else if (ctl.rem) begin
      if (cell_idx >= ctl.pos) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign cell_val = val_r;

endmodule

@@ rtl/indexed_sequence_list_core.sv @@
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   isl_pkg::in_item_t (cmd, position, value_in)
// out_     output     out_valid/out_stall isl_pkg::out_item_t (value_out, status, length)
//
// On each accepted command all cells shift left, shift right or hold in
// parallel, and the answer lands in the output register on the accepting edge.
// A new item is taken every cycle while the output register is empty or drained.
// Reset clears the element count and the output valid; cell contents stay
// undefined until written. A stalled output holds its item and stalls the input.
module indexed_sequence_list_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  isl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output isl_pkg::out_item_t  out_data
);

  logic [isl_pkg::CNT_W-1:0]        count_r;
  logic [isl_pkg::CNT_W-1:0]        count_nxt;
  logic                             out_valid_r;
  isl_pkg::out_item_t               out_data_r;
  logic                             accept;
  isl_pkg::cell_ctl_t               ctl;
  isl_pkg::cell_ctl_t               ctl_gated;
  logic [isl_pkg::IDX_W-1:0]        rd_idx;
  logic                             rd_en;
  isl_pkg::status_t                 status;
  logic                             empty;
  logic                             full;
  logic [isl_pkg::CMP_W-1:0]        pos_c;
  logic [isl_pkg::CMP_W-1:0]        cnt_c;
  logic [isl_pkg::IDX_W-1:0]        pos_idx;
  logic [isl_pkg::IDX_W-1:0]        last_idx;
  logic signed [isl_pkg::VAL_W-1:0] cell_val [isl_pkg::CAPACITY];
  logic signed [isl_pkg::VAL_W-1:0] rd_val;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign empty    = (count_r == '0);
  assign full     = (count_r == isl_pkg::CNT_W'(isl_pkg::CAPACITY));
  assign pos_c    = isl_pkg::CMP_W'(in_data.position);
  assign cnt_c    = isl_pkg::CMP_W'(count_r);
  assign pos_idx  = isl_pkg::IDX_W'(in_data.position);
  assign last_idx = isl_pkg::IDX_W'(count_r - isl_pkg::CNT_W'(1));

  always_comb begin
    ctl       = '0;
    rd_idx    = '0;
    rd_en     = 1'b0;
    status    = isl_pkg::ST_OK;
    count_nxt = count_r;
    unique case (in_data.cmd)
      isl_pkg::CMD_PREPEND: begin
        if (full) begin
          status = isl_pkg::ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          count_nxt = count_r + isl_pkg::CNT_W'(1);
        end
      end
      isl_pkg::CMD_APPEND: begin
        if (full) begin
          status = isl_pkg::ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          ctl.pos   = isl_pkg::IDX_W'(count_r);
          count_nxt = count_r + isl_pkg::CNT_W'(1);
        end
      end
      isl_pkg::CMD_POP_LAST: begin
        if (empty) begin
          status = isl_pkg::ST_EMPTY;
        end else begin
          rd_idx    = last_idx;
          rd_en     = 1'b1;
          count_nxt = count_r - isl_pkg::CNT_W'(1);
        end
      end
      isl_pkg::CMD_POP_FIRST: begin
        if (empty) begin
          status = isl_pkg::ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          ctl.rem   = 1'b1;
          count_nxt = count_r - isl_pkg::CNT_W'(1);
        end
      end
      isl_pkg::CMD_FIRST: begin
        if (empty) begin
          status = isl_pkg::ST_EMPTY;
        end else begin
          rd_en = 1'b1;
        end
      end
      isl_pkg::CMD_LAST: begin
        if (empty) begin
          status = isl_pkg::ST_EMPTY;
        end else begin
          rd_idx = last_idx;
          rd_en  = 1'b1;
        end
      end
      isl_pkg::CMD_GET: begin
        if (empty) begin
          status = isl_pkg::ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status = isl_pkg::ST_INDEX;
        end else begin
          rd_idx = pos_idx;
          rd_en  = 1'b1;
        end
      end
      isl_pkg::CMD_REMOVE: begin
        if (empty) begin
          status = isl_pkg::ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          status = isl_pkg::ST_INDEX;
        end else begin
          rd_idx    = pos_idx;
          rd_en     = 1'b1;
          ctl.rem   = 1'b1;
          ctl.pos   = pos_idx;
          count_nxt = count_r - isl_pkg::CNT_W'(1);
        end
      end
      isl_pkg::CMD_INSERT: begin
        // A full list is reported ahead of a bad index.
        if (full) begin
          status = isl_pkg::ST_FULL;
        end else if (pos_c > cnt_c) begin
          status = isl_pkg::ST_INDEX;
        end else begin
          ctl.ins   = 1'b1;
          ctl.pos   = pos_idx;
          count_nxt = count_r + isl_pkg::CNT_W'(1);
        end
      end
      isl_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl_gated     = ctl;
    ctl_gated.ins = ctl.ins & accept;
    ctl_gated.rem = ctl.rem & accept;
  end

  genvar gi;
  generate
    for (gi = 0; gi < isl_pkg::CAPACITY; gi++) begin : g_cell
      logic signed [isl_pkg::VAL_W-1:0] left_val;
      logic signed [isl_pkg::VAL_W-1:0] right_val;
      if (gi == 0) begin : g_first
        assign left_val = '0;
      end else begin : g_left
        assign left_val = cell_val[gi-1];
      end
      if (gi == isl_pkg::CAPACITY - 1) begin : g_last
        assign right_val = '0;
      end else begin : g_right
        assign right_val = cell_val[gi+1];
      end
      isl_cell u_cell (
        .clk       (clk),
        .ctl       (ctl_gated),
        .cell_idx  (isl_pkg::IDX_W'(gi)),
        .din       (in_data.value_in),
        .left_val  (left_val),
        .right_val (right_val),
        .cell_val  (cell_val[gi])
      );
    end
  endgenerate

  assign rd_val = rd_en ? cell_val[rd_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.value_out <= rd_val;
      out_data_r.status    <= status;
      out_data_r.length    <= isl_pkg::LEN_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sv/tb_indexed_sequence_list_core.sv @@
module tb_indexed_sequence_list_core;
  import isl_pkg::*;

  localparam int MAX_IDLE       = 16;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int PHASE_LEN      = 110;
  localparam int SEND_STRETCH   = 75;
  localparam int RECV_STRETCH   = 60;
  localparam int HOLD_AFTER     = 200;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 250000;
  localparam int GROW_PCT       = 85;
  localparam int SHRINK_PCT     = 25;
  localparam int EVEN_PCT       = 50;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  // Shadow copy of the list; it predicts the answer to every accepted command.
  class list_shadow;
    logic signed [VAL_W-1:0] cells [CAPACITY];
    int unsigned             count;
    out_item_t               answers_due [$];
    int                      errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void open_at(int unsigned pos, logic signed [VAL_W-1:0] val);
      for (int unsigned k = count; k > pos; k--) cells[k] = cells[k-1];
      cells[pos] = val;
      count++;
    endfunction

    function logic signed [VAL_W-1:0] close_at(int unsigned pos);
      logic signed [VAL_W-1:0] taken;
      taken = cells[pos];
      for (int unsigned k = pos; k + 1 < count; k++) cells[k] = cells[k+1];
      count--;
      return taken;
    endfunction

    function void take_command(in_item_t it);
      out_item_t ans;
      bit        full;
      bit        empty;
      full  = (count >= CAPACITY);
      empty = (count == 0);
      ans.value_out = '0;
      ans.status    = ST_OK;
      case (it.cmd)
        CMD_PREPEND: begin
          if (full) ans.status = ST_FULL;
          else open_at(0, it.value_in);
        end
        CMD_APPEND: begin
          if (full) ans.status = ST_FULL;
          else open_at(count, it.value_in);
        end
        CMD_POP_LAST: begin
          if (empty) ans.status = ST_EMPTY;
          else ans.value_out = close_at(count - 1);
        end
        CMD_POP_FIRST: begin
          if (empty) ans.status = ST_EMPTY;
          else ans.value_out = close_at(0);
        end
        CMD_FIRST: begin
          if (empty) ans.status = ST_EMPTY;
          else ans.value_out = cells[0];
        end
        CMD_LAST: begin
          if (empty) ans.status = ST_EMPTY;
          else ans.value_out = cells[count-1];
        end
        CMD_GET: begin
          if (empty) ans.status = ST_EMPTY;
          else if (it.position >= count) ans.status = ST_INDEX;
          else ans.value_out = cells[it.position];
        end
        CMD_REMOVE: begin
          if (empty) ans.status = ST_EMPTY;
          else if (it.position >= count) ans.status = ST_INDEX;
          else ans.value_out = close_at(it.position);
        end
        CMD_INSERT: begin
          // A full list is reported before the index is looked at.
          if (full) ans.status = ST_FULL;
          else if (it.position > count) ans.status = ST_INDEX;
          else open_at(it.position, it.value_in);
        end
        CMD_CLEAR: count = 0;
        default: ;
      endcase
      ans.length = LEN_W'(count);
      answers_due.push_back(ans);
    endfunction

    function void check_answer(out_item_t got);
      out_item_t want;
      if (answers_due.size() == 0) begin
        $error("unexpected result item: value_out %0d status %0d length %0d",
               got.value_out, got.status, got.length);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (got.value_out !== want.value_out) begin
        $error("value_out mismatch: expected %0d, got %0d", want.value_out, got.value_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("length mismatch: expected %0d, got %0d", want.length, got.length);
        errors++;
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  list_shadow shadow = new();
  bit         send_burst = 1'b0;
  bit         recv_burst = 1'b0;
  int         cycle_count = 0;

  indexed_sequence_list_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("indexed_sequence_list_core test failed");
      $finish;
    end
  end

  function automatic in_item_t cmd_item(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                        logic [VAL_W-1:0] val);
    in_item_t it;
    it.cmd      = cmd;
    it.position = pos;
    it.value_in = val;
    return it;
  endfunction

  // Commands are drawn around the current length so that most of them get past
  // the empty, full and index checks; add_pct steers the list toward full or empty.
  function automatic in_item_t random_item(int unsigned len, int add_pct);
    in_item_t it;
    int       pick;
    case ($urandom_range(0, 9))
      0:       it.value_in = 32'h7fff_ffff;
      1:       it.value_in = 32'h8000_0000;
      2:       it.value_in = 32'hffff_ffff;
      3:       it.value_in = '0;
      default: it.value_in = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       it.position = POS_W'($urandom_range(0, 127));
      1:       it.position = POS_W'(len);
      default: it.position = POS_W'($urandom_range(0, (len == 0) ? 0 : len - 1));
    endcase
    pick = $urandom_range(0, 199);
    if (pick == 199) begin
      it.cmd = CMD_CLEAR;
    end else if (pick >= 196) begin
      it.cmd = CMD_W'($urandom_range(int'(CMD_SPARE_LO), int'(CMD_SPARE_HI)));
    end else if (pick < 2 * add_pct) begin
      case ($urandom_range(0, 2))
        0:       it.cmd = CMD_PREPEND;
        1:       it.cmd = CMD_APPEND;
        default: it.cmd = CMD_INSERT;
      endcase
    end else begin
      it.cmd = CMD_W'($urandom_range(int'(CMD_POP_LAST), int'(CMD_REMOVE)));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    shadow.take_command(it);
  endtask

  // Result side: random stall per item, one long hold-off to back up the block.
  initial begin
    int hold;
    int taken;
    bit held_long;
    taken     = 0;
    held_long = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (!held_long && taken == HOLD_AFTER) begin
        held_long = 1'b1;
        hold      = LONG_HOLD;
      end else begin
        hold = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      shadow.check_answer(out_data);
      taken++;
      if (taken % RECV_STRETCH == 0) recv_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int add_pct;
    add_pct  = GROW_PCT;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every take and read on an empty list, then single-element pops.
    send_item(cmd_item(CMD_POP_LAST, 7'd0, 32'd0));
    send_item(cmd_item(CMD_POP_FIRST, 7'd0, 32'd0));
    send_item(cmd_item(CMD_FIRST, 7'd0, 32'd0));
    send_item(cmd_item(CMD_LAST, 7'd0, 32'd0));
    send_item(cmd_item(CMD_GET, 7'd0, 32'd0));
    send_item(cmd_item(CMD_REMOVE, 7'd127, 32'd0));
    send_item(cmd_item(CMD_INSERT, 7'd1, 32'd9));
    send_item(cmd_item(CMD_INSERT, 7'd0, 32'h7fff_ffff));
    send_item(cmd_item(CMD_POP_LAST, 7'd0, 32'd0));
    send_item(cmd_item(CMD_APPEND, 7'd0, 32'h8000_0000));
    send_item(cmd_item(CMD_POP_FIRST, 7'd0, 32'd0));
    // A few elements, reads at both ends, index bounds and insert at the end.
    send_item(cmd_item(CMD_PREPEND, 7'd0, 32'hffff_ffff));
    send_item(cmd_item(CMD_APPEND, 7'd0, 32'd0));
    send_item(cmd_item(CMD_INSERT, 7'd1, 32'd5));
    send_item(cmd_item(CMD_INSERT, 7'd3, 32'h1234_5678));
    send_item(cmd_item(CMD_GET, 7'd2, 32'd0));
    send_item(cmd_item(CMD_GET, 7'd64, 32'd0));
    send_item(cmd_item(CMD_INSERT, 7'd5, 32'd1));
    send_item(cmd_item(CMD_REMOVE, 7'd1, 32'd0));
    send_item(cmd_item(CMD_FIRST, 7'd0, 32'd0));
    send_item(cmd_item(CMD_LAST, 7'd0, 32'd0));
    send_item(cmd_item(CMD_SPARE_HI, 7'd127, 32'hffff_ffff));
    send_item(cmd_item(CMD_SPARE_LO, 7'd0, 32'd0));
    send_item(cmd_item(CMD_CLEAR, 7'd0, 32'd0));
    send_item(cmd_item(CMD_CLEAR, 7'd0, 32'd0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_LEN == 0) begin
        case ((i / PHASE_LEN) % 3)
          0:       add_pct = GROW_PCT;
          1:       add_pct = SHRINK_PCT;
          default: add_pct = EVEN_PCT;
        endcase
      end
      if (i % SEND_STRETCH == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_item(random_item(shadow.count, add_pct));
    end
    in_valid <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("indexed_sequence_list_core test passed");
    end else begin
      $display("indexed_sequence_list_core test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/isl_pkg.sv
rtl/isl_cell.sv
rtl/indexed_sequence_list_core.sv
tb/sv/tb_indexed_sequence_list_core.sv
